[hdl/pspv_pkg.sv]
// Package with the shared types, codes and constants of the pedal sensor plausibility voter.
package pspv_pkg;

  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int UPDATE_PERIOD_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int NUM_SAMPLES = 3;

  localparam logic [CMD_W-1:0] CMD_STORE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TRIGGER = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RECOVERABLE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IMPL_ERROR = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_TIMER_FAIL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEVIATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 1'd1;

  localparam logic [UPDATE_PERIOD_W-1:0] UPDATE_PERIOD_RST = 16'd10;

  typedef enum logic [3:0] {
    MODE_OK          = 4'b0001,
    MODE_RECOVERABLE = 4'b0010,
    MODE_IMPL_ERROR  = 4'b0100,
    MODE_TIMER_FAIL  = 4'b1000
  } mode_t;

  function automatic logic [STATUS_W-1:0] mode_status(input mode_t mode);
    logic [STATUS_W-1:0] code;
    case (mode)
      MODE_OK:          code = STATUS_OK;
      MODE_RECOVERABLE: code = STATUS_RECOVERABLE;
      MODE_IMPL_ERROR:  code = STATUS_IMPL_ERROR;
      MODE_TIMER_FAIL:  code = STATUS_TIMER_FAIL;
      default:          code = STATUS_OK;
    endcase
    return code;
  endfunction

endpackage

[hdl/pspv_if.sv]
// Valid/ready channel interfaces for the voter's input commands and its results.
interface pspv_in_if #(
  parameter int FRAC_BITS = 16,
  parameter int TIME_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [pspv_pkg::CMD_W-1:0]  cmd;
  logic signed [FRAC_BITS+1:0] sample_first;
  logic signed [FRAC_BITS+1:0] sample_second;
  logic signed [FRAC_BITS+1:0] sample_third;
  logic [TIME_BITS-1:0]        now_time;
  logic                        timer_ok;

  modport source (
    output valid, cmd, sample_first, sample_second, sample_third, now_time, timer_ok,
    input  ready
  );
  modport sink (
    input  valid, cmd, sample_first, sample_second, sample_third, now_time, timer_ok,
    output ready
  );
endinterface

interface pspv_out_if #(
  parameter int FRAC_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic [pspv_pkg::STATUS_W-1:0]  status;
  logic [FRAC_BITS:0]             travel;
  logic                           timer_start;
  logic                           timer_stop;
  logic                           evaluated;

  modport source (
    output valid, status, travel, timer_start, timer_stop, evaluated,
    input  ready
  );
  modport sink (
    input  valid, status, travel, timer_start, timer_stop, evaluated,
    output ready
  );
endinterface

[hdl/pedal_sensor_plausibility_voter_top.sv]
// Top level of the pedal sensor plausibility voter.
// An accepted transaction is held in the input register, then passes through the
// voting logic into the result register.
// Throughput: one per cycle unless stalled, from the single-pass vote and mode update.
// Reset (synchronous, rst_n low) empties both registers, returns the mode to ok, clears
// the samples, held travel, pending timeout and last evaluation time, and loads the
// configuration reset values.
module pedal_sensor_plausibility_voter_top #(
  parameter int FRAC_BITS = 16,
  parameter int TIME_BITS = 32,
  localparam int CFG_W = (FRAC_BITS + 1 > pspv_pkg::UPDATE_PERIOD_W) ?
                         FRAC_BITS + 1 : pspv_pkg::UPDATE_PERIOD_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pspv_in_if.sink                          in_ch,
  pspv_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [pspv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]                 cfg_wdata
);
  import pspv_pkg::*;

  localparam int SAMPLE_W = FRAC_BITS + 2;
  localparam int TRAVEL_W = FRAC_BITS + 1;
  localparam int SUM_W = FRAC_BITS + 2;
  localparam int DIV3_K = SUM_W + 2;
  localparam longint DIV3_M = ((longint'(1) << DIV3_K) + 2) / 3;
  localparam int PROD_W = SUM_W + DIV3_K;
  localparam logic [TRAVEL_W-1:0] ONE_VALUE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [TRAVEL_W-1:0] MAX_DEV_RST =
    TRAVEL_W'(((longint'(1) << FRAC_BITS) + 5) / 10);

  logic [TRAVEL_W-1:0]        max_dev_r;
  logic [UPDATE_PERIOD_W-1:0] period_r;

  logic                       s1_valid_r, s1_valid_nxt;
  logic [CMD_W-1:0]           s1_cmd_r;
  logic [SAMPLE_W-1:0]        s1_samples_r [NUM_SAMPLES];
  logic [TIME_BITS-1:0]       s1_now_r;
  logic                       s1_tok_r;

  logic [SAMPLE_W-1:0]        samples_r [NUM_SAMPLES];
  logic [SAMPLE_W-1:0]        samples_nxt [NUM_SAMPLES];
  mode_t                      mode_r, mode_nxt;
  logic [TRAVEL_W-1:0]        held_r, held_nxt;
  logic                       pending_r, pending_nxt;
  logic [TIME_BITS-1:0]       last_eval_r, last_eval_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]        out_status_r;
  logic [TRAVEL_W-1:0]        out_travel_r;
  logic                       out_start_r, out_stop_r, out_eval_r;
  logic                       start_nxt, stop_nxt, eval_nxt;

  logic                       adv;
  logic                       in_acc;
  logic [NUM_SAMPLES-1:0]     smp_ok;
  logic [NUM_SAMPLES-1:0]     pair_good;
  logic [TRAVEL_W-1:0]        pair_diff [NUM_SAMPLES];
  logic [SUM_W-1:0]           pair_sum [NUM_SAMPLES];
  logic [SUM_W-1:0]           sum3;
  logic [PROD_W-1:0]          prod3;
  logic [TRAVEL_W-1:0]        mean3;
  logic [TRAVEL_W-1:0]        vote_value;
  logic                       plausible;
  logic [TIME_BITS-1:0]       elapsed;
  logic                       gate_pass;

  assign adv = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_acc = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.travel = out_travel_r;
  assign out_ch.timer_start = out_start_r;
  assign out_ch.timer_stop = out_stop_r;
  assign out_ch.evaluated = out_eval_r;

  always_comb begin
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      smp_ok[i] = !samples_r[i][SAMPLE_W-1] && (samples_r[i][TRAVEL_W-1:0] <= ONE_VALUE);
    end
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      if (samples_r[i][TRAVEL_W-1:0] >= samples_r[(i + 1) % NUM_SAMPLES][TRAVEL_W-1:0]) begin
        pair_diff[i] = samples_r[i][TRAVEL_W-1:0] -
                       samples_r[(i + 1) % NUM_SAMPLES][TRAVEL_W-1:0];
      end else begin
        pair_diff[i] = samples_r[(i + 1) % NUM_SAMPLES][TRAVEL_W-1:0] -
                       samples_r[i][TRAVEL_W-1:0];
      end
      pair_good[i] = smp_ok[i] && smp_ok[(i + 1) % NUM_SAMPLES] && (pair_diff[i] <= max_dev_r);
      pair_sum[i] = {1'b0, samples_r[i][TRAVEL_W-1:0]} +
                    {1'b0, samples_r[(i + 1) % NUM_SAMPLES][TRAVEL_W-1:0]};
    end
  end

  assign sum3 = {1'b0, samples_r[0][TRAVEL_W-1:0]} + {1'b0, samples_r[1][TRAVEL_W-1:0]} +
                {1'b0, samples_r[2][TRAVEL_W-1:0]};
  assign prod3 = PROD_W'(sum3) * PROD_W'(DIV3_K'(DIV3_M));
  assign mean3 = prod3[DIV3_K +: TRAVEL_W];

  always_comb begin
    plausible = |pair_good;
    if (&pair_good) begin
      vote_value = mean3;
    end else if (pair_good[2]) begin
      vote_value = pair_sum[2][SUM_W-1:1];
    end else if (pair_good[1]) begin
      vote_value = pair_sum[1][SUM_W-1:1];
    end else begin
      vote_value = pair_sum[0][SUM_W-1:1];
    end
  end

  assign elapsed = s1_now_r - last_eval_r;
  assign gate_pass = elapsed >= TIME_BITS'(period_r);

  always_comb begin
    samples_nxt = samples_r;
    mode_nxt = mode_r;
    held_nxt = held_r;
    pending_nxt = pending_r;
    last_eval_nxt = last_eval_r;
    start_nxt = 1'b0;
    stop_nxt = 1'b0;
    eval_nxt = 1'b0;
    if (adv) begin
      case (s1_cmd_r)
        CMD_STORE: begin
          samples_nxt = s1_samples_r;
        end
        CMD_TRIGGER: begin
          pending_nxt = 1'b1;
        end
        CMD_TICK: begin
          if (gate_pass) begin
            last_eval_nxt = s1_now_r;
            if (mode_r == MODE_OK || mode_r == MODE_RECOVERABLE) begin
              eval_nxt = 1'b1;
              if (pending_r) begin
                mode_nxt = MODE_IMPL_ERROR;
                pending_nxt = 1'b0;
              end else if (mode_r == MODE_OK) begin
                if (plausible) begin
                  held_nxt = vote_value;
                end else begin
                  start_nxt = 1'b1;
                  mode_nxt = s1_tok_r ? MODE_RECOVERABLE : MODE_TIMER_FAIL;
                end
              end else if (plausible) begin
                stop_nxt = 1'b1;
                if (s1_tok_r) begin
                  mode_nxt = MODE_OK;
                  held_nxt = vote_value;
                end else begin
                  mode_nxt = MODE_TIMER_FAIL;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dev_r <= MAX_DEV_RST;
      period_r <= UPDATE_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_DEVIATION: max_dev_r <= cfg_wdata[TRAVEL_W-1:0];
        CFG_UPDATE_PERIOD: period_r <= cfg_wdata[UPDATE_PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SAMPLES; i++) begin
        samples_r[i] <= '0;
      end
      mode_r <= MODE_OK;
      held_r <= '0;
      pending_r <= 1'b0;
      last_eval_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      samples_r <= samples_nxt;
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      pending_r <= pending_nxt;
      last_eval_r <= last_eval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_ch.cmd;
      s1_samples_r[0] <= in_ch.sample_first;
      s1_samples_r[1] <= in_ch.sample_second;
      s1_samples_r[2] <= in_ch.sample_third;
      s1_now_r <= in_ch.now_time;
      s1_tok_r <= in_ch.timer_ok;
    end
    if (adv) begin
      out_status_r <= mode_status(mode_nxt);
      out_travel_r <= held_nxt;
      out_start_r <= start_nxt;
      out_stop_r <= stop_nxt;
      out_eval_r <= eval_nxt;
    end
  end

`ifndef SYNTHESIS
  a_error_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IMPL_ERROR || mode_r == MODE_TIMER_FAIL) |=> (mode_r == $past(mode_r)))
    else $error("error mode left");

  a_eval_updates_time: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && eval_nxt) |=> (last_eval_r == $past(s1_now_r)))
    else $error("evaluation did not record its time");

  a_start_only_from_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && start_nxt) |-> (eval_nxt && mode_r == MODE_OK && !pending_r && !stop_nxt))
    else $error("timer start requested outside ok evaluation");

  a_stop_only_from_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stop_nxt) |-> (eval_nxt && mode_r == MODE_RECOVERABLE && plausible))
    else $error("timer stop requested outside recoverable evaluation");

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_cmd_r) && $stable(s1_now_r)))
    else $error("stalled transaction lost from input register");
`endif

endmodule

[tb/pedal_sensor_plausibility_voter_top_tb.sv]
// Self-checking testbench for the pedal sensor plausibility voter, predicting each result.
module pedal_sensor_plausibility_voter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pspv_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int TIME_BITS = 32;
  localparam int SAMPLE_W = FRAC_BITS + 2;
  localparam int TRAVEL_W = FRAC_BITS + 1;
  localparam int TRAVEL_ONE = 1 << FRAC_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TRAVEL_W-1:0] travel;
    logic                timer_start;
    logic                timer_stop;
    logic                evaluated;
  } reading_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TRAVEL_W-1:0] cfg_wdata;

  pspv_in_if #(.FRAC_BITS(FRAC_BITS), .TIME_BITS(TIME_BITS)) cmd_ch ();
  pspv_out_if #(.FRAC_BITS(FRAC_BITS)) reading_ch ();

  pedal_sensor_plausibility_voter_top #(
    .FRAC_BITS(FRAC_BITS),
    .TIME_BITS(TIME_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(cmd_ch),
    .out_ch(reading_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic signed [SAMPLE_W-1:0] pedal_samples [3] = '{default: '0};
  logic [STATUS_W-1:0] voter_mode = STATUS_OK;
  logic [TRAVEL_W-1:0] held_travel = '0;
  logic timeout_armed = 1'b0;
  logic [TIME_BITS-1:0] last_eval_ms = '0;
  logic [TRAVEL_W-1:0] max_dev = 17'd6554;
  logic [UPDATE_PERIOD_W-1:0] eval_period = UPDATE_PERIOD_RST;

  reading_t expected_readings [$];
  logic [TIME_BITS-1:0] clock_ms = '0;
  int error_count = 0;
  int cycles_run = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_order = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit vote_travel(output logic [TRAVEL_W-1:0] voted);
    int a, b, gap, good_pairs, last_pair, sum;
    good_pairs = 0;
    last_pair = 0;
    voted = '0;
    for (int i = 0; i < 3; i++) begin
      a = int'(pedal_samples[i]);
      b = int'(pedal_samples[(i + 1) % 3]);
      if (a >= 0 && a <= TRAVEL_ONE && b >= 0 && b <= TRAVEL_ONE) begin
        gap = (a > b) ? a - b : b - a;
        if (gap <= int'(max_dev)) begin
          good_pairs++;
          last_pair = i;
        end
      end
    end
    if (good_pairs == 3) begin
      sum = int'(pedal_samples[0]) + int'(pedal_samples[1]) + int'(pedal_samples[2]);
      voted = TRAVEL_W'(sum / 3);
    end else if (good_pairs > 0) begin
      sum = int'(pedal_samples[last_pair]) + int'(pedal_samples[(last_pair + 1) % 3]);
      voted = TRAVEL_W'(sum / 2);
    end
    return good_pairs > 0;
  endfunction

  function automatic reading_t predict_reading(input logic [CMD_W-1:0] cmd,
                                               input logic signed [SAMPLE_W-1:0] first,
                                               input logic signed [SAMPLE_W-1:0] second,
                                               input logic signed [SAMPLE_W-1:0] third,
                                               input logic [TIME_BITS-1:0] now,
                                               input logic tok);
    reading_t r;
    logic [TRAVEL_W-1:0] voted;
    logic [TIME_BITS-1:0] elapsed;
    bit plausible;
    r = '0;
    case (cmd)
      CMD_STORE: begin
        pedal_samples[0] = first;
        pedal_samples[1] = second;
        pedal_samples[2] = third;
      end
      CMD_TRIGGER: timeout_armed = 1'b1;
      CMD_TICK: begin
        elapsed = now - last_eval_ms;
        if (elapsed >= TIME_BITS'(eval_period)) begin
          last_eval_ms = now;
          if (voter_mode == STATUS_OK || voter_mode == STATUS_RECOVERABLE) begin
            plausible = vote_travel(voted);
            r.evaluated = 1'b1;
            if (timeout_armed) begin
              voter_mode = STATUS_IMPL_ERROR;
              timeout_armed = 1'b0;
            end else if (voter_mode == STATUS_OK) begin
              if (plausible) begin
                held_travel = voted;
              end else begin
                r.timer_start = 1'b1;
                voter_mode = tok ? STATUS_RECOVERABLE : STATUS_TIMER_FAIL;
              end
            end else if (plausible) begin
              r.timer_stop = 1'b1;
              if (tok) begin
                voter_mode = STATUS_OK;
                held_travel = voted;
              end else begin
                voter_mode = STATUS_TIMER_FAIL;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.status = voter_mode;
    r.travel = held_travel;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("Field %s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    reading_t want;
    cycles_run <= cycles_run + 1;
    if (rst_n) begin
      if (reading_ch.valid && reading_ch.ready) begin
        if (expected_readings.size() == 0) begin
          $error("Result transaction arrived with no expectation pending");
          error_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("status", 32'(want.status), 32'(reading_ch.status));
          check_field("travel", 32'(want.travel), 32'(reading_ch.travel));
          check_field("timer_start", 32'(want.timer_start), 32'(reading_ch.timer_start));
          check_field("timer_stop", 32'(want.timer_stop), 32'(reading_ch.timer_stop));
          check_field("evaluated", 32'(want.evaluated), 32'(reading_ch.evaluated));
        end
      end
      if (cmd_ch.valid && cmd_ch.ready)
        expected_readings.push_back(predict_reading(cmd_ch.cmd, cmd_ch.sample_first,
                                                    cmd_ch.sample_second, cmd_ch.sample_third,
                                                    cmd_ch.now_time, cmd_ch.timer_ok));
    end
  end

  always @(posedge clk) begin
    if (hold_order > 0) begin
      hold_left = hold_order;
      hold_order = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      reading_ch.ready <= 1'b0;
    end else begin
      reading_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  initial begin
    while (cycles_run < CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [SAMPLE_W-1:0] first,
                          input logic signed [SAMPLE_W-1:0] second,
                          input logic signed [SAMPLE_W-1:0] third,
                          input logic [TIME_BITS-1:0] now, input logic tok);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= cmd;
    cmd_ch.sample_first <= first;
    cmd_ch.sample_second <= second;
    cmd_ch.sample_third <= third;
    cmd_ch.now_time <= now;
    cmd_ch.timer_ok <= tok;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic store_samples(input logic signed [SAMPLE_W-1:0] first,
                               input logic signed [SAMPLE_W-1:0] second,
                               input logic signed [SAMPLE_W-1:0] third);
    send_cmd(CMD_STORE, first, second, third, $urandom(), 1'($urandom_range(1)));
  endtask

  task automatic tick_at(input logic [TIME_BITS-1:0] now, input logic tok);
    clock_ms = now;
    send_cmd(CMD_TICK, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()), SAMPLE_W'($urandom()),
             now, tok);
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [TRAVEL_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    if (index == CFG_MAX_DEVIATION)
      max_dev = value;
    else
      eval_period = value[UPDATE_PERIOD_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic retune_voter();
    drain_results();
    if ($urandom_range(3) == 0)
      write_register(CFG_MAX_DEVIATION, TRAVEL_W'($urandom_range(0, TRAVEL_ONE)));
    else
      write_register(CFG_MAX_DEVIATION, TRAVEL_W'($urandom_range(0, 9000)));
    write_register(CFG_UPDATE_PERIOD, TRAVEL_W'($urandom_range(0, 40)));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_travel(input int centre);
    int spread, v;
    spread = int'(max_dev) + 64;
    case ($urandom_range(11))
      0: v = int'($urandom());
      1: v = int'($urandom_range(0, 2)) - 1;
      2: v = TRAVEL_ONE + int'($urandom_range(0, 2)) - 1;
      default: v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // Risky items may arm the timeout or refuse the timer, which can end in a permanent error mode.
  task automatic send_random_item(input bit risky);
    int pick, centre, period;
    logic [TIME_BITS-1:0] step;
    logic tok;
    pick = $urandom_range(99);
    centre = $urandom_range(0, TRAVEL_ONE);
    period = int'(eval_period);
    tok = 1'($urandom_range(1));
    if (pick < 44) begin
      store_samples(pick_travel(centre), pick_travel(centre), pick_travel(centre));
    end else if (pick < 92) begin
      case ($urandom_range(9))
        0: step = $urandom();
        1, 2, 3: step = period;
        4: step = period - 1;
        default: step = $urandom_range(0, 2 * period + 2);
      endcase
      tick_at(clock_ms + step, risky ? ($urandom_range(99) >= 8) : 1'b1);
    end else if (!risky || pick < 99) begin
      send_cmd(CMD_UNUSED, pick_travel(centre), pick_travel(centre), pick_travel(centre),
               $urandom(), tok);
    end else begin
      send_cmd(CMD_TRIGGER, pick_travel(centre), pick_travel(centre), pick_travel(centre),
               $urandom(), tok);
    end
  endtask

  task automatic test_period_gate();
    tick_at(32'd5, 1'b1);
    tick_at(32'd10, 1'b1);
    tick_at(32'd19, 1'b1);
    tick_at(32'hFFFF_FFFF, 1'b1);
    tick_at(32'd8, 1'b1);
    tick_at(32'd9, 1'b1);
  endtask

  task automatic test_vote_cases();
    store_samples(18'sd65536, 18'sd65536, 18'sd65536);
    tick_at(clock_ms + 32'd10, 1'b1);
    store_samples(18'sd0, 18'sd6554, 18'sd3000);
    tick_at(clock_ms + 32'd10, 1'b1);
    store_samples(18'sd1000, 18'sd7555, 18'sd1000);
    tick_at(clock_ms + 32'd10, 1'b1);
    store_samples(18'sd1000, 18'sd5000, 18'sd9000);
    tick_at(clock_ms + 32'd10, 1'b1);
    store_samples(18'sd65537, -18'sd1, 18'sd131071);
    send_cmd(CMD_UNUSED, 18'sd0, 18'sd0, 18'sd0, clock_ms, 1'b1);
    tick_at(clock_ms + 32'd10, 1'b1);
    tick_at(clock_ms + 32'd10, 1'b1);
    store_samples(-18'sd131072, 18'sd40000, 18'sd40001);
    tick_at(clock_ms + 32'd10, 1'b1);
  endtask

  task automatic test_config_extremes();
    drain_results();
    write_register(CFG_MAX_DEVIATION, 17'd0);
    write_register(CFG_UPDATE_PERIOD, 17'd0);
    store_samples(18'sd500, 18'sd500, 18'sd501);
    tick_at(clock_ms, 1'b1);
    tick_at(clock_ms, 1'b1);
    drain_results();
    write_register(CFG_MAX_DEVIATION, 17'd65536);
    write_register(CFG_UPDATE_PERIOD, 17'd65535);
    store_samples(18'sd0, 18'sd65536, 18'sd0);
    tick_at(clock_ms + 32'd65534, 1'b1);
    tick_at(clock_ms + 32'd1, 1'b1);
    drain_results();
  endtask

  task automatic test_random_traffic(input int items, input int sender_pct,
                                     input int receiver_pct, input bit risky);
    sender_idle_pct = sender_pct;
    receiver_idle_pct = receiver_pct;
    for (int n = 0; n < items; n++) begin
      if (n % 160 == 0)
        retune_voter();
      send_random_item(risky);
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    hold_order = 300;
    repeat (60) send_random_item(1'b0);
    drain_results();
  endtask

  task automatic test_error_modes();
    write_register(CFG_UPDATE_PERIOD, 17'd5);
    if ($urandom_range(1))
      store_samples(-18'sd5, 18'sd70000, 18'sd131071);
    else
      send_cmd(CMD_TRIGGER, 18'sd0, 18'sd0, 18'sd0, clock_ms, 1'b1);
    tick_at(clock_ms + 32'd5, 1'b0);
    send_cmd(CMD_TRIGGER, 18'sd0, 18'sd0, 18'sd0, clock_ms, 1'b1);
    tick_at(clock_ms + 32'd4, 1'b1);
    tick_at(clock_ms + 32'd1, 1'b1);
    tick_at(clock_ms + 32'd5, 1'b0);
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_STORE;
    cmd_ch.sample_first = '0;
    cmd_ch.sample_second = '0;
    cmd_ch.sample_third = '0;
    cmd_ch.now_time = '0;
    cmd_ch.timer_ok = 1'b0;
    reading_ch.ready = 1'b0;
    sender_idle_pct = 13;
    receiver_idle_pct = 79;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_period_gate();
    test_vote_cases();
    test_config_extremes();
    test_random_traffic(650, 13, 79, 1'b0);
    test_backpressure();
    test_random_traffic(650, 79, 13, 1'b0);
    test_random_traffic(550, 0, 0, 1'b1);
    test_error_modes();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
